// ----- sv/wspu_pkg.sv -----
// Shared types, constants and helpers for the WS2812 pixel update transmitter.
// No dependencies; imported by every module of the block.
package wspu_pkg;

    localparam int CFG_W  = 16;   // timing register width
    localparam int PIX_W  = 24;   // one GRB word
    localparam int CHAR_W = 8;
    localparam int NIB_W  = 4;
    localparam int BIT_W  = 5;    // bit cursor, 0..23
    localparam int TGT_W  = 9;    // y*ROW_LENGTH+x, at most 135 with ROW_LENGTH 8

    localparam logic [BIT_W-1:0] BIT_TOP = 5'd23;

    localparam logic [CFG_W-1:0] ONE_HIGH_RST  = 16'd80;
    localparam logic [CFG_W-1:0] ONE_LOW_RST   = 16'd45;
    localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 16'd40;
    localparam logic [CFG_W-1:0] ZERO_LOW_RST  = 16'd85;

    typedef enum logic [1:0] {
        CFG_ONE_HIGH  = 2'd0,
        CFG_ONE_LOW   = 2'd1,
        CFG_ZERO_HIGH = 2'd2,
        CFG_ZERO_LOW  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] one_high;
        logic [CFG_W-1:0] one_low;
        logic [CFG_W-1:0] zero_high;
        logic [CFG_W-1:0] zero_low;
    } cfg_t;

    typedef struct packed {
        logic rejected;
        logic busy;
        logic level;
    } res_t;

    // Only '0'-'9' and 'A'-'F' are digits; anything else reads as zero.
    function automatic logic [NIB_W-1:0] hex_nib(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        return d[NIB_W-1:0];
    endfunction

    function automatic logic [7:0] hex_byte(input logic [CHAR_W-1:0] hi,
                                            input logic [CHAR_W-1:0] lo);
        return {hex_nib(hi), hex_nib(lo)};
    endfunction

endpackage

// ----- sv/wspu_pix_mem.sv -----
// Pixel store: GRB words with per-entry valid bits so unwritten entries read zero.
// Registered read with write-through bypass; uses wspu_pkg.
module wspu_pix_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [wspu_pkg::PIX_W-1:0] wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [wspu_pkg::PIX_W-1:0] rd_data
);
    import wspu_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [PIX_W-1:0] rd_word_reg;
    logic             rd_hit_reg;
    logic             bypass;

    assign bypass = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= bypass ? wr_data : mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= bypass || valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

// ----- sv/wspu_core.sv -----
// Command decode and frame timing: one item per call, state updated on proc.
// Uses wspu_pkg; reads pixel words prefetched by wspu_pix_mem.
module wspu_core #(
    parameter int LED_COUNT  = 64,
    parameter int ROW_LENGTH = 8,
    parameter int TICK_WIDTH = 16,
    parameter int IDX_W      = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        proc,
    input  logic                        kind,
    input  logic [wspu_pkg::CHAR_W-1:0] x_char,
    input  logic [wspu_pkg::CHAR_W-1:0] y_char,
    input  logic [wspu_pkg::CHAR_W-1:0] red_high_char,
    input  logic [wspu_pkg::CHAR_W-1:0] red_low_char,
    input  logic [wspu_pkg::CHAR_W-1:0] green_high_char,
    input  logic [wspu_pkg::CHAR_W-1:0] green_low_char,
    input  logic [wspu_pkg::CHAR_W-1:0] blue_high_char,
    input  logic [wspu_pkg::CHAR_W-1:0] blue_low_char,
    input  wspu_pkg::cfg_t              cfg,
    input  logic [wspu_pkg::PIX_W-1:0]  cur_word,
    output wspu_pkg::res_t              res,
    output logic                        mem_we,
    output logic [IDX_W-1:0]            mem_waddr,
    output logic [wspu_pkg::PIX_W-1:0]  mem_wdata,
    output logic [IDX_W-1:0]            mem_raddr,
    output logic                        busy
);
    import wspu_pkg::*;

    localparam int CMP_W = (TICK_WIDTH + 1 > CFG_W) ? TICK_WIDTH + 1 : CFG_W;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << TICK_WIDTH;

    logic                  sending_reg, sending_next;
    logic                  low_reg, low_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [IDX_W-1:0]      led_reg, led_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;

    logic [TGT_W-1:0] target;
    logic             tgt_bad;
    logic             one;
    logic [CFG_W-1:0] sel_ticks;
    logic [CMP_W-1:0] len;
    logic [CMP_W-1:0] tick_inc;

    assign target = TGT_W'(hex_nib(y_char)) * TGT_W'(ROW_LENGTH) + TGT_W'(hex_nib(x_char));
    assign tgt_bad = target >= TGT_W'(LED_COUNT);

    assign one = cur_word[bit_reg];

    always_comb begin
        if (low_reg) begin
            sel_ticks = one ? cfg.one_low : cfg.zero_low;
        end else begin
            sel_ticks = one ? cfg.one_high : cfg.zero_high;
        end
        len = (sel_ticks == '0) ? CMP_W'(1) : CMP_W'(sel_ticks);
        if (len > LIMIT) begin
            len = LIMIT;
        end
    end

    assign tick_inc = CMP_W'(tick_reg) + CMP_W'(1);

    assign mem_waddr = target[IDX_W-1:0];
    assign mem_wdata = {hex_byte(green_high_char, green_low_char),
                        hex_byte(red_high_char, red_low_char),
                        hex_byte(blue_high_char, blue_low_char)};

    always_comb begin
        sending_next = sending_reg;
        low_next     = low_reg;
        bit_next     = bit_reg;
        led_next     = led_reg;
        last_next    = last_reg;
        tick_next    = tick_reg;
        res          = '0;
        mem_we       = 1'b0;
        if (proc) begin
            if (kind) begin
                res.level = sending_reg && !low_reg;
                if (sending_reg || tgt_bad) begin
                    res.rejected = 1'b1;
                end else begin
                    mem_we       = 1'b1;
                    last_next    = target[IDX_W-1:0];
                    led_next     = '0;
                    bit_next     = BIT_TOP;
                    low_next     = 1'b0;
                    tick_next    = '0;
                    sending_next = 1'b1;
                    res.level    = 1'b0;
                end
                res.busy = sending_next;
            end else if (sending_reg) begin
                res.busy  = 1'b1;
                res.level = !low_reg;
                if (tick_inc >= len) begin
                    tick_next = '0;
                    if (!low_reg) begin
                        low_next = 1'b1;
                    end else begin
                        low_next = 1'b0;
                        if (bit_reg != '0) begin
                            bit_next = bit_reg - BIT_W'(1);
                        end else begin
                            bit_next = BIT_TOP;
                            if (led_reg >= last_reg) begin
                                sending_next = 1'b0;
                                led_next     = '0;
                            end else begin
                                led_next = led_reg + IDX_W'(1);
                            end
                        end
                    end
                end else begin
                    tick_next = tick_inc[TICK_WIDTH-1:0];
                end
            end
        end
    end

    // prefetch the word for the LED the next item will see
    assign mem_raddr = led_next;
    assign busy      = sending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg <= 1'b0;
            low_reg     <= 1'b0;
            bit_reg     <= BIT_TOP;
            led_reg     <= '0;
            last_reg    <= '0;
            tick_reg    <= '0;
        end else begin
            sending_reg <= sending_next;
            low_reg     <= low_next;
            bit_reg     <= bit_next;
            led_reg     <= led_next;
            last_reg    <= last_next;
            tick_reg    <= tick_next;
        end
    end

endmodule

// ----- sv/ws2812_pixel_update_transmitter.sv -----
// Top level of the WS2812 pixel update transmitter: stream ports, timing registers,
// input and result registers; instantiates wspu_core and wspu_pix_mem, uses wspu_pkg.
//
// Each transfer on s_ is either one line tick (tuser 0) or a pixel update command
// (tuser 1, eight ASCII hex characters in tdata). One result per item comes out on m_:
// the input register takes the transfer, then the decode/timing logic fills the result
// register, which drives m_tvalid. A new item is taken every cycle as long as m_tready
// keeps up; the input and result registers are the only buffering, so s_tready follows
// m_tready when both registers are full. The pixel word of the LED being sent is read
// from the pixel store ahead of its use, so the store's single read port never limits
// the rate. The store's reset to zero is done by per-entry valid bits; no clearing pass
// is needed. Timing registers are written through cfg_*; the user must write them only
// while no item is in flight, the block itself does not enforce it; a frame in
// progress picks up new timing from its next tick.
module ws2812_pixel_update_transmitter #(
    parameter int LED_COUNT  = 64,
    parameter int ROW_LENGTH = 8,
    parameter int TICK_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: x_char, y_char, red_high_char, red_low_char,
    //        green_high_char, green_low_char, blue_high_char, blue_low_char
    input  logic [63:0] s_tdata,
    // tuser: kind
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: line_level, busy_res, rejected, zero padding
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [wspu_pkg::CFG_W-1:0] cfg_wdata
);
    import wspu_pkg::*;

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    cfg_t cfg_reg;

    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [63:0] in_data_reg;
    logic        m_valid_reg;
    res_t        m_res_reg;

    logic             out_free;
    logic             proc;
    res_t             res;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [PIX_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [PIX_W-1:0] cur_word;
    logic             core_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_high  <= ONE_HIGH_RST;
            cfg_reg.one_low   <= ONE_LOW_RST;
            cfg_reg.zero_high <= ZERO_HIGH_RST;
            cfg_reg.zero_low  <= ZERO_LOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_ONE_HIGH:  cfg_reg.one_high  <= cfg_wdata;
                CFG_ONE_LOW:   cfg_reg.one_low   <= cfg_wdata;
                CFG_ZERO_HIGH: cfg_reg.zero_high <= cfg_wdata;
                CFG_ZERO_LOW:  cfg_reg.zero_low  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (proc) begin
            m_res_reg <= res;
        end
    end

    wspu_core #(
        .LED_COUNT  (LED_COUNT),
        .ROW_LENGTH (ROW_LENGTH),
        .TICK_WIDTH (TICK_WIDTH),
        .IDX_W      (IDX_W)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .proc            (proc),
        .kind            (in_kind_reg),
        .x_char          (in_data_reg[7:0]),
        .y_char          (in_data_reg[15:8]),
        .red_high_char   (in_data_reg[23:16]),
        .red_low_char    (in_data_reg[31:24]),
        .green_high_char (in_data_reg[39:32]),
        .green_low_char  (in_data_reg[47:40]),
        .blue_high_char  (in_data_reg[55:48]),
        .blue_low_char   (in_data_reg[63:56]),
        .cfg             (cfg_reg),
        .cur_word        (cur_word),
        .res             (res),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .busy            (core_busy)
    );

    wspu_pix_mem #(
        .DEPTH (LED_COUNT),
        .AW    (IDX_W)
    ) u_pix_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (cur_word)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_res_reg.rejected, m_res_reg.busy, m_res_reg.level};

    // a pixel is only stored when no frame is running
    a_store_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !core_busy)
        else $error("pixel store written during a frame");

    // an accepted command always starts a frame
    a_store_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> core_busy)
        else $error("frame not started after pixel store write");

    // an empty result register never holds off the input side
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with result register empty");

    // a result is loaded only from a valid input stage
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(in_valid_reg))
        else $error("result appeared without an input item");

endmodule

// ----- sim/tb_ws2812_pixel_update_transmitter.sv -----
// Testbench for ws2812_pixel_update_transmitter: drives ticks and pixel update commands,
// mirrors the frame timing and pixel store, and checks every result field.
// Depends on wspu_pkg and the RTL of the block only.
module tb_ws2812_pixel_update_transmitter;
    import wspu_pkg::*;

    localparam int LEDS        = 64;
    localparam int ROW_LEN     = 8;
    localparam int STALL_LIMIT = 1000;

    logic        aclk;
    logic        aresetn;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    // mirror of the line state
    cfg_t        line_cfg;
    logic [PIX_W-1:0] pix_mirror [LEDS];
    int          led_cur;
    int          last_led_m;
    int          bit_cur;
    int          tick_cnt;
    logic        low_phase;
    logic        line_sending;

    res_t        line_result_q [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          live_items;
    int          err_count;
    int          stall_cycles;

    ws2812_pixel_update_transmitter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [3:0] nib_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        c = {4'h0, v};
        return (v < 4'd10) ? c + 8'h30 : c + 8'h37;
    endfunction

    // Random character: half valid digits, half anything (lower case, punctuation...)
    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        c = 8'($urandom);
        if ($urandom_range(1) == 0) begin
            c = hex_char(c[3:0]);
        end
        return c;
    endfunction

    function automatic logic [63:0] pixel_word(input logic [3:0] x, input logic [3:0] y,
                                               input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        return {hex_char(b[3:0]), hex_char(b[7:4]), hex_char(g[3:0]), hex_char(g[7:4]),
                hex_char(r[3:0]), hex_char(r[7:4]), hex_char(y), hex_char(x)};
    endfunction

    // Random characters, coordinates kept to the first two LEDs so frames stay short
    function automatic logic [63:0] rand_cmd_word();
        logic [7:0] xc;
        logic [7:0] yc;
        xc = rand_char();
        yc = rand_char();
        if (nib_of(xc) > 4'd1) begin
            xc = hex_char(4'($urandom_range(1)));
        end
        if (nib_of(yc) != 4'd0) begin
            yc = "0";
        end
        return {rand_char(), rand_char(), rand_char(), rand_char(),
                rand_char(), rand_char(), yc, xc};
    endfunction

    // Advances the line mirror by one accepted item and returns the expected result.
    function automatic res_t advance_line_model(input logic kind, input logic [63:0] d);
        res_t r;
        int   tgt;
        logic one_bit;
        int   plen;
        r = '0;
        if (kind) begin
            tgt = int'(nib_of(d[15:8])) * ROW_LEN + int'(nib_of(d[7:0]));
            r.level = line_sending && !low_phase;
            if (line_sending || tgt >= LEDS) begin
                r.rejected = 1'b1;
            end else begin
                pix_mirror[tgt] = {nib_of(d[39:32]), nib_of(d[47:40]),
                                   nib_of(d[23:16]), nib_of(d[31:24]),
                                   nib_of(d[55:48]), nib_of(d[63:56])};
                last_led_m   = tgt;
                led_cur      = 0;
                bit_cur      = 23;
                low_phase    = 1'b0;
                tick_cnt     = 0;
                line_sending = 1'b1;
                r.level      = 1'b0;
            end
            r.busy = line_sending;
        end else if (line_sending) begin
            one_bit = pix_mirror[led_cur][bit_cur];
            r.busy  = 1'b1;
            r.level = !low_phase;
            if (low_phase) begin
                plen = one_bit ? int'(line_cfg.one_low) : int'(line_cfg.zero_low);
            end else begin
                plen = one_bit ? int'(line_cfg.one_high) : int'(line_cfg.zero_high);
            end
            if (plen == 0) begin
                plen = 1;
            end
            tick_cnt++;
            if (tick_cnt >= plen) begin
                tick_cnt = 0;
                if (!low_phase) begin
                    low_phase = 1'b1;
                end else begin
                    low_phase = 1'b0;
                    if (bit_cur != 0) begin
                        bit_cur--;
                    end else begin
                        bit_cur = 23;
                        if (led_cur >= last_led_m) begin
                            line_sending = 1'b0;
                            led_cur      = 0;
                        end else begin
                            led_cur++;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Called and returns at a falling edge.
    task automatic drain_results(input int hold);
        s_tvalid = 1'b0;
        wait (line_result_q.size() == 0);
        repeat (hold) @(negedge aclk);
    endtask

    task automatic send_item(input logic kind, input logic [63:0] d);
        res_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        if ($urandom_range(299) == 0) begin
            drain_results(1);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
        r = advance_line_model(kind, d);
        line_result_q.push_back(r);
        if (kind || r.busy) begin
            live_items++;
        end
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_item(1'b0, {$urandom, $urandom});
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_tick();
    endtask

    task automatic finish_frame();
        while (line_sending) send_tick();
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_ONE_HIGH:  line_cfg.one_high  = val;
            CFG_ONE_LOW:   line_cfg.one_low   = val;
            CFG_ZERO_HIGH: line_cfg.zero_high = val;
            CFG_ZERO_LOW:  line_cfg.zero_low  = val;
            default: ;
        endcase
    endtask

    // Pipeline empty before any register moves; a running frame takes the new timing.
    task automatic set_timing(input logic [CFG_W-1:0] oh, input logic [CFG_W-1:0] ol,
                              input logic [CFG_W-1:0] zh, input logic [CFG_W-1:0] zl);
        drain_results(4);
        write_reg(CFG_ONE_HIGH, oh);
        write_reg(CFG_ONE_LOW, ol);
        write_reg(CFG_ZERO_HIGH, zh);
        write_reg(CFG_ZERO_LOW, zl);
    endtask

    task automatic test_idle_ticks();
        run_ticks(5);
    endtask

    // Reset timings over the first two bits, commands landing in the high and the low phase.
    task automatic test_default_frame();
        send_item(1'b1, pixel_word(4'h0, 4'h0, 8'h5A, 8'hA5, 8'hC3));
        run_ticks(10);
        send_item(1'b1, pixel_word(4'h1, 4'h0, 8'h11, 8'h22, 8'h33));
        run_ticks(100);
        send_item(1'b1, pixel_word(4'h2, 4'h0, 8'h44, 8'h55, 8'h66));
        run_ticks(140);
    endtask

    task automatic test_hex_decode();
        finish_frame();
        send_item(1'b1, pixel_word(4'h1, 4'h0, 8'hFF, 8'h00, 8'h81));
        finish_frame();
        // lower case and out-of-set characters all read as zero
        send_item(1'b1, {"a", "f", "@", ":", "/", "G", 8'hFF, "b"});
        finish_frame();
        send_item(1'b1, {"F", "9", "0", "A", "E", "1", "0", "1"});
        finish_frame();
        send_item(1'b1, 64'h0);
        finish_frame();
        send_item(1'b1, {8{8'hFF}});
        finish_frame();
    endtask

    task automatic test_index_range();
        send_item(1'b1, pixel_word(4'h0, 4'h8, 8'hAA, 8'hAA, 8'hAA));  // 64
        send_item(1'b1, pixel_word(4'hF, 4'h7, 8'hAA, 8'hAA, 8'hAA));  // 71
        send_item(1'b1, pixel_word(4'hF, 4'hF, 8'hAA, 8'hAA, 8'hAA));  // 135
        send_item(1'b1, pixel_word(4'h8, 4'h7, 8'hAA, 8'hAA, 8'hAA));  // column runs past the end
        send_item(1'b1, pixel_word(4'h8, 4'h0, 8'h0F, 8'hF0, 8'h3C));  // column wraps to row 1
        finish_frame();
    endtask

    // Long phases on a single bit of the stretched kind so the frame stays bounded.
    task automatic test_timing_extremes();
        finish_frame();
        set_timing(16'd260, 16'd3, 16'd1, 16'd1);
        send_item(1'b1, pixel_word(4'h0, 4'h0, 8'h00, 8'h00, 8'h01));
        run_ticks(20);
        send_item(1'b1, pixel_word(4'h1, 4'h0, 8'h00, 8'h00, 8'h00));
        finish_frame();
    endtask

    task automatic test_random_traffic(input int budget);
        int stop_at;
        int pick;
        logic [3:0] x;
        stop_at = live_items + budget;
        set_timing(CFG_W'($urandom_range(2)), CFG_W'($urandom_range(3)),
                   CFG_W'($urandom_range(3)), CFG_W'($urandom_range(2)));
        while (live_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                // mostly one or two LEDs per frame, now and then a column past the row
                x = ($urandom_range(9) == 0) ? 4'($urandom_range(9)) : 4'($urandom_range(1));
                send_item(1'b1, pixel_word(x, 4'h0, 8'($urandom), 8'($urandom),
                                           8'($urandom)));
                while (line_sending) begin
                    if ($urandom_range(19) == 0) begin
                        send_item(1'b1, rand_cmd_word());
                    end else begin
                        send_tick();
                    end
                end
            end else if (pick < 85) begin
                send_item(1'b1, rand_cmd_word());
            end else if (pick < 92) begin
                send_item(1'b1, pixel_word(4'($urandom), 4'($urandom_range(15, 8)),
                                           8'($urandom), 8'($urandom), 8'($urandom)));
            end else begin
                send_tick();
            end
        end
    endtask

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2:0];
            if (line_result_q.size() == 0) begin
                report_mismatch("unexpected transfer", int'(m_tdata), -1);
            end else begin
                want = line_result_q.pop_front();
                if (got.level !== want.level)
                    report_mismatch("line_level", int'(got.level), int'(want.level));
                if (got.busy !== want.busy)
                    report_mismatch("busy_res", int'(got.busy), int'(want.busy));
                if (got.rejected !== want.rejected)
                    report_mismatch("rejected", int'(got.rejected), int'(want.rejected));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tvalid      = 1'b0;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_ONE_HIGH;
        cfg_wdata     = '0;
        send_idle_pct = 32;
        recv_idle_pct = 65;
        live_items    = 0;
        err_count     = 0;
        stall_cycles  = 0;
        line_cfg      = '{ONE_HIGH_RST, ONE_LOW_RST, ZERO_HIGH_RST, ZERO_LOW_RST};
        foreach (pix_mirror[i]) pix_mirror[i] = '0;
        led_cur       = 0;
        last_led_m    = 0;
        bit_cur       = 23;
        tick_cnt      = 0;
        low_phase     = 1'b0;
        line_sending  = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_ticks();
        test_default_frame();
        set_timing(16'd0, 16'd0, 16'd0, 16'd0);
        test_hex_decode();
        set_timing(16'd1, 16'd1, 16'd1, 16'd1);
        test_index_range();
        test_random_traffic(160);

        send_idle_pct = 65;
        recv_idle_pct = 32;
        test_random_traffic(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(160);
        test_timing_extremes();

        finish_frame();
        drain_results(1);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
